### rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define GB5_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gb5 same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during rst.
`define GB5_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gb5 next-cycle check failed");

`endif

### rtl/core/gb5_pkg.sv
`default_nettype none

package gb5_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int KSIZE        = 5;
  localparam int LINES        = KSIZE - 1;
  localparam int PIX_W        = 8;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int IMG_W_W      = 11;
  localparam int HEIGHT_W     = 16;
  localparam int ROW_W        = HEIGHT_W + 1;
  localparam int LINE_WORD_W  = LINES * PIX_W;
  localparam int CSUM_W       = 15;
  localparam int SUM_W        = 17;
  localparam int RECIP_W      = 19;
  localparam int PROD_W       = SUM_W + RECIP_W;
  localparam int RECIP_SHIFT  = 27;
  localparam int COLQ_DEPTH   = 4;
  localparam int COLQ_PTR_W   = $clog2(COLQ_DEPTH);
  localparam int COLQ_CNT_W   = COLQ_PTR_W + 1;
  localparam int OUTQ_DEPTH   = 8;
  localparam int OUTQ_PTR_W   = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W   = OUTQ_PTR_W + 1;
  localparam int ROW_END_BURST = 3;
  localparam int CFG_INDEX_W  = 4;
  localparam int CFG_DATA_W   = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_W'(1);

  localparam logic [IMG_W_W-1:0]  WIDTH_RESET  = IMG_W_W'(640);
  localparam logic [IMG_W_W-1:0]  WIDTH_MIN    = IMG_W_W'(5);
  localparam logic [IMG_W_W-1:0]  WIDTH_MAX    = IMG_W_W'(MAX_WIDTH);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);

  // Reciprocal of 273 scaled by 2**27, rounded up; exact for all sums below 255*273+1.
  localparam logic [RECIP_W-1:0] RECIP_273 = RECIP_W'(491641);

  // Vertical profiles of the kernel columns: outer rows, inner rows, center row.
  localparam logic [CSUM_W-1:0] WA_OUT = CSUM_W'(1);
  localparam logic [CSUM_W-1:0] WA_IN  = CSUM_W'(4);
  localparam logic [CSUM_W-1:0] WA_CTR = CSUM_W'(7);
  localparam logic [CSUM_W-1:0] WB_OUT = CSUM_W'(4);
  localparam logic [CSUM_W-1:0] WB_IN  = CSUM_W'(16);
  localparam logic [CSUM_W-1:0] WB_CTR = CSUM_W'(26);
  localparam logic [CSUM_W-1:0] WC_OUT = CSUM_W'(7);
  localparam logic [CSUM_W-1:0] WC_IN  = CSUM_W'(26);
  localparam logic [CSUM_W-1:0] WC_CTR = CSUM_W'(41);

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             flush;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             row_end;
    logic             frame_end;
  } pix_out_t;

  typedef struct packed {
    logic [KSIZE-1:0][PIX_W-1:0] pix;
    logic                        clear;
    logic                        emit;
    logic                        last_col;
    logic                        last_row;
  } col_item_t;

  typedef struct packed {
    logic      valid;
    col_item_t item;
  } col_xfer_t;

  function automatic logic [CSUM_W-1:0] col_sum(
    input logic [KSIZE-1:0][PIX_W-1:0] p,
    input logic [CSUM_W-1:0]           w_out,
    input logic [CSUM_W-1:0]           w_in,
    input logic [CSUM_W-1:0]           w_ctr
  );
    logic [CSUM_W-1:0] outer_sum;
    logic [CSUM_W-1:0] inner_sum;
    outer_sum = CSUM_W'(p[0]) + CSUM_W'(p[KSIZE-1]);
    inner_sum = CSUM_W'(p[1]) + CSUM_W'(p[KSIZE-2]);
    return w_out * outer_sum + w_in * inner_sum + w_ctr * CSUM_W'(p[2]);
  endfunction

endpackage

`default_nettype wire

### rtl/core/gb5_ram.sv
`default_nettype none

module gb5_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/gb5_front.sv
`default_nettype none

module gb5_front
  import gb5_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  output logic                        full,
  input  wire pix_in_t                din,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic [COLQ_CNT_W-1:0]  colq_count,
  output col_xfer_t                   col_wr
);

  logic [IMG_W_W-1:0]     image_width;
  logic [HEIGHT_W-1:0]    image_height;
  logic [COL_W-1:0]       column_count;
  logic [ROW_W-1:0]       row_count;

  logic                   s1_valid;
  logic [COL_W-1:0]       s1_addr;
  logic [PIX_W-1:0]       s1_px;
  logic [LINES-1:0]       s1_mask;
  logic                   s1_clear;
  logic                   s1_emit;
  logic                   s1_last_col;
  logic                   s1_last_row;

  logic [IMG_W_W-1:0]     w_eff;
  logic [HEIGHT_W-1:0]    h_eff;
  logic [COL_W-1:0]       col;
  logic [ROW_W-1:0]       row;
  logic [PIX_W-1:0]       px;
  logic                   accept;
  logic                   last_col;
  logic                   last_row;
  logic [LINE_WORD_W-1:0] rd_data;
  logic [LINE_WORD_W-1:0] wr_data;

  always_comb begin
    if (image_width < WIDTH_MIN) begin
      w_eff = WIDTH_MIN;
    end else if (image_width > WIDTH_MAX) begin
      w_eff = WIDTH_MAX;
    end else begin
      w_eff = image_width;
    end
  end

  assign h_eff     = (image_height == '0) ? HEIGHT_W'(1) : image_height;
  assign col       = (IMG_W_W'(column_count) >= w_eff) ? '0 : column_count;
  assign row       = row_count;
  assign px        = (din.flush || row >= ROW_W'(h_eff)) ? '0 : din.pixel_in;
  assign full      = (COLQ_CNT_W'(colq_count) + COLQ_CNT_W'(s1_valid))
                     >= COLQ_CNT_W'(COLQ_DEPTH);
  assign accept    = push && !full;
  assign last_col  = (IMG_W_W'(col) + IMG_W_W'(1)) >= w_eff;
  assign last_row  = row >= (ROW_W'(h_eff) + ROW_W'(1));
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      column_count <= '0;
      row_count    <= '0;
      s1_valid     <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        if (last_col) begin
          column_count <= '0;
          row_count    <= last_row ? '0 : row + ROW_W'(1);
        end else begin
          column_count <= col + COL_W'(1);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_WIDTH: begin
            image_width  <= cfg_data[IMG_W_W-1:0];
            column_count <= '0;
            row_count    <= '0;
          end
          REG_IMAGE_HEIGHT: begin
            image_height <= cfg_data[HEIGHT_W-1:0];
            column_count <= '0;
            row_count    <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr     <= col;
      s1_px       <= px;
      s1_mask[0]  <= row >= ROW_W'(4);
      s1_mask[1]  <= row >= ROW_W'(3);
      s1_mask[2]  <= row >= ROW_W'(2);
      s1_mask[3]  <= row >= ROW_W'(1);
      s1_clear    <= col == '0;
      s1_emit     <= (row >= ROW_W'(2)) && (col >= COL_W'(2));
      s1_last_col <= last_col;
      s1_last_row <= last_row;
    end
  end

  // Each column word holds the four previous rows, oldest in the low byte.
  assign wr_data = {s1_px, rd_data[LINE_WORD_W-1:PIX_W]};

  gb5_ram #(
    .WIDTH (LINE_WORD_W),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_addr),
    .wdata (wr_data),
    .re    (accept),
    .raddr (col),
    .rdata (rd_data)
  );

  always_comb begin
    col_wr.valid         = s1_valid;
    for (int k = 0; k < LINES; k++) begin
      col_wr.item.pix[k] = s1_mask[k] ? rd_data[k*PIX_W +: PIX_W] : '0;
    end
    col_wr.item.pix[KSIZE-1] = s1_px;
    col_wr.item.clear    = s1_clear;
    col_wr.item.emit     = s1_emit;
    col_wr.item.last_col = s1_last_col;
    col_wr.item.last_row = s1_last_row;
  end

endmodule

`default_nettype wire

### rtl/core/gb5_colq.sv
`default_nettype none

module gb5_colq
  import gb5_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire col_xfer_t             col_wr,
  output logic      [COLQ_CNT_W-1:0] count,
  output col_xfer_t                  col_rd,
  input  wire logic                  pop
);

  col_item_t               entries [COLQ_DEPTH];
  logic [COLQ_PTR_W-1:0]   wr_ptr;
  logic [COLQ_PTR_W-1:0]   rd_ptr;
  logic                    do_pop;

  assign do_pop      = pop && (count != '0);
  assign col_rd.valid = count != '0;
  assign col_rd.item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (col_wr.valid) begin
        wr_ptr <= wr_ptr + COLQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + COLQ_PTR_W'(1);
      end
      count <= count + COLQ_CNT_W'(col_wr.valid) - COLQ_CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (col_wr.valid) begin
      entries[wr_ptr] <= col_wr.item;
    end
  end

endmodule

`default_nettype wire

### rtl/core/gb5_back.sv
`default_nettype none

module gb5_back
  import gb5_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire col_xfer_t              col_rd,
  output logic                        colq_pop,
  output logic                        empty,
  input  wire logic                   pop,
  output pix_out_t                    dout,
  output logic      [OUTQ_CNT_W-1:0]  outq_count
);

  logic [CSUM_W-1:0]     ha [KSIZE];
  logic [CSUM_W-1:0]     hb [KSIZE];
  logic [CSUM_W-1:0]     hc [KSIZE];

  logic                  v1;
  logic                  f1_emit;
  logic                  f1_last;
  logic                  f1_last_row;
  logic                  v2;
  logic [SUM_W-1:0]      s_a;
  logic [SUM_W-1:0]      s_b;
  logic [SUM_W-1:0]      s_c;
  logic                  f2_last;
  logic                  f2_last_row;
  logic                  v3;
  logic [PIX_W-1:0]      q_a;
  logic [PIX_W-1:0]      q_b;
  logic [PIX_W-1:0]      q_c;
  logic                  f3_last;
  logic                  f3_last_row;

  logic                  en;
  logic                  room;
  logic [OUTQ_CNT_W-1:0] need;
  logic [OUTQ_CNT_W-1:0] n_wr;
  logic                  oq_wr;
  logic                  oq_rd;
  logic [PROD_W-1:0]     p_a;
  logic [PROD_W-1:0]     p_b;
  logic [PROD_W-1:0]     p_c;

  pix_out_t              oq [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wr_ptr;
  logic [OUTQ_PTR_W-1:0] rd_ptr;

  assign need     = f3_last ? OUTQ_CNT_W'(ROW_END_BURST) : OUTQ_CNT_W'(1);
  assign room     = (OUTQ_CNT_W'(OUTQ_DEPTH) - outq_count) >= need;
  assign oq_wr    = v3 && room;
  assign en       = !v3 || room;
  assign colq_pop = en && col_rd.valid;
  assign n_wr     = oq_wr ? need : '0;
  assign empty    = outq_count == '0;
  assign oq_rd    = pop && !empty;
  assign dout     = oq[rd_ptr];

  assign p_a = PROD_W'(s_a) * PROD_W'(RECIP_273);
  assign p_b = PROD_W'(s_b) * PROD_W'(RECIP_273);
  assign p_c = PROD_W'(s_c) * PROD_W'(RECIP_273);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= colq_pop;
      v2 <= v1 && f1_emit;
      v3 <= v2;
    end
  end

  // The history keeps the three column sums of the newest five columns, newest first.
  always_ff @(posedge clk) begin
    if (en) begin
      if (colq_pop) begin
        ha[0] <= col_sum(col_rd.item.pix, WA_OUT, WA_IN, WA_CTR);
        hb[0] <= col_sum(col_rd.item.pix, WB_OUT, WB_IN, WB_CTR);
        hc[0] <= col_sum(col_rd.item.pix, WC_OUT, WC_IN, WC_CTR);
        for (int i = 1; i < KSIZE; i++) begin
          ha[i] <= col_rd.item.clear ? '0 : ha[i-1];
          hb[i] <= col_rd.item.clear ? '0 : hb[i-1];
          hc[i] <= col_rd.item.clear ? '0 : hc[i-1];
        end
        f1_emit     <= col_rd.item.emit;
        f1_last     <= col_rd.item.last_col;
        f1_last_row <= col_rd.item.last_row;
      end
      s_a <= SUM_W'(ha[0]) + SUM_W'(hb[1]) + SUM_W'(hc[2]) + SUM_W'(hb[3]) + SUM_W'(ha[4]);
      s_b <= SUM_W'(hb[0]) + SUM_W'(hc[1]) + SUM_W'(hb[2]) + SUM_W'(ha[3]);
      s_c <= SUM_W'(hc[0]) + SUM_W'(hb[1]) + SUM_W'(ha[2]);
      f2_last     <= f1_last;
      f2_last_row <= f1_last_row;
      q_a <= p_a[RECIP_SHIFT +: PIX_W];
      q_b <= p_b[RECIP_SHIFT +: PIX_W];
      q_c <= p_c[RECIP_SHIFT +: PIX_W];
      f3_last     <= f2_last;
      f3_last_row <= f2_last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      outq_count <= '0;
    end else begin
      wr_ptr     <= wr_ptr + OUTQ_PTR_W'(n_wr);
      if (oq_rd) begin
        rd_ptr <= rd_ptr + OUTQ_PTR_W'(1);
      end
      outq_count <= outq_count + n_wr - OUTQ_CNT_W'(oq_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (oq_wr) begin
      oq[wr_ptr].pixel_out <= q_a;
      oq[wr_ptr].row_end   <= 1'b0;
      oq[wr_ptr].frame_end <= 1'b0;
      if (f3_last) begin
        oq[wr_ptr + OUTQ_PTR_W'(1)].pixel_out <= q_b;
        oq[wr_ptr + OUTQ_PTR_W'(1)].row_end   <= 1'b0;
        oq[wr_ptr + OUTQ_PTR_W'(1)].frame_end <= 1'b0;
        oq[wr_ptr + OUTQ_PTR_W'(2)].pixel_out <= q_c;
        oq[wr_ptr + OUTQ_PTR_W'(2)].row_end   <= 1'b1;
        oq[wr_ptr + OUTQ_PTR_W'(2)].frame_end <= f3_last_row;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/gaussian_blur_5x5.sv
// 5x5 Gaussian blur for an 8-bit grayscale frame streamed in raster order.
// Input queue side: an item transfers when push is high and full is low. The
// host sends image_height image rows and then two rows of padding items,
// each row image_width items long.
// Result queue side: the oldest result sits on dout while empty is low and
// transfers when pop is high. Input column c >= 2 of row r >= 2 gives output
// pixel (r-2, c-2); the last column of a row gives three pixels, the third
// with row_end set and, in the last padding row, frame_end set.
// Configuration: cfg_index 0 is image_width, 1 is image_height; a transfer
// to either restarts the frame. Write only while the block is idle.
// One item is taken per cycle while full is low. It passes the front
// stage, the column queue and a three-stage arithmetic pipeline, which
// run on their own, into an eight-entry result buffer that soaks up the
// three-pixel bursts at row ends. When the receiver stalls the buffer
// fills, the pipeline holds, the column queue fills and full rises.
// Reset restores 640 by 480 and starts a new frame; the line memory needs no
// clearing because rows above the top edge are masked.
`default_nettype none

`include "assert_macros.svh"

module gaussian_blur_5x5
  import gb5_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  output logic                        full,
  input  wire pix_in_t                din,
  output logic                        empty,
  input  wire logic                   pop,
  output pix_out_t                    dout,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  col_xfer_t             col_wr;
  col_xfer_t             col_rd;
  logic [COLQ_CNT_W-1:0] colq_count;
  logic                  colq_pop;
  logic [OUTQ_CNT_W-1:0] outq_count;

  gb5_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .din        (din),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .colq_count (colq_count),
    .col_wr     (col_wr)
  );

  gb5_colq u_colq (
    .clk    (clk),
    .rst    (rst),
    .col_wr (col_wr),
    .count  (colq_count),
    .col_rd (col_rd),
    .pop    (colq_pop)
  );

  gb5_back u_back (
    .clk        (clk),
    .rst        (rst),
    .col_rd     (col_rd),
    .colq_pop   (colq_pop),
    .empty      (empty),
    .pop        (pop),
    .dout       (dout),
    .outq_count (outq_count)
  );

  `GB5_ASSERT_NEXT(a_accept_reaches_queue, push && !full, col_wr.valid)
  `GB5_ASSERT_SAME(a_colq_no_overflow, col_wr.valid, (colq_count < COLQ_CNT_W'(COLQ_DEPTH)) || colq_pop)
  `GB5_ASSERT_SAME(a_outq_bounded, 1'b1, outq_count <= OUTQ_CNT_W'(OUTQ_DEPTH))

endmodule

`default_nettype wire
